// ----- src/dtoi_pkg.sv -----
// Shared types and constants for the decimal text to integer converter.
`default_nettype none

package dtoi_pkg;

	localparam int unsigned VALUE_W = 64;

	// Target kind codes.
	localparam logic [1:0] KIND_INT64  = 2'd0;
	localparam logic [1:0] KIND_UINT64 = 2'd1;
	localparam logic [1:0] KIND_INT32  = 2'd2;
	localparam logic [1:0] KIND_UINT32 = 2'd3;

	// Characters of interest.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [1:0] kind;
	} ch_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid_res;
	} res_word_t;

	// Everything the range check needs about one finished text.
	typedef struct packed {
		logic [VALUE_W-1:0] accum;
		logic               is_negative;
		logic               parsed;
		logic [1:0]         held_kind;
	} text_snap_t;

endpackage

`default_nettype wire

// ----- src/dtoi_accum.sv -----
// Per-text parse state: sign handling, digit accumulation and overflow detection.
`default_nettype none

module dtoi_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  dtoi_pkg::ch_word_t    word,
	output dtoi_pkg::text_snap_t  snap
);

	logic [dtoi_pkg::VALUE_W-1:0] accum_q;
	logic                         is_negative_q;
	logic                         failed_q;
	logic                         at_start_q;
	logic                         digit_seen_q;
	logic [1:0]                   held_kind_q;

	logic [dtoi_pkg::VALUE_W-1:0] accum_d;
	logic                         is_negative_d;
	logic                         failed_d;
	logic                         digit_seen_d;
	logic [1:0]                   held_kind_d;

	logic       is_digit;
	logic [7:0] diff;
	logic [3:0] digit;
	logic [dtoi_pkg::VALUE_W+3:0] prod;
	logic       overflow;
	logic       kind_signed;
	logic       do_digit;

	assign is_digit = (word.ch >= dtoi_pkg::CH_ZERO) && (word.ch <= dtoi_pkg::CH_NINE);
	assign diff     = word.ch - dtoi_pkg::CH_ZERO;
	assign digit    = diff[3:0];

	// accum*10 + digit as 8*accum + 2*accum + digit; any carry past 64 bits is overflow.
	assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
		+ {{dtoi_pkg::VALUE_W{1'b0}}, digit};
	assign overflow = |prod[dtoi_pkg::VALUE_W+3:dtoi_pkg::VALUE_W];

	assign kind_signed = (word.kind == dtoi_pkg::KIND_INT64)
		|| (word.kind == dtoi_pkg::KIND_INT32);

	always_comb begin
		accum_d       = accum_q;
		is_negative_d = is_negative_q;
		failed_d      = failed_q;
		digit_seen_d  = digit_seen_q;
		held_kind_d   = held_kind_q;
		do_digit      = 1'b0;
		if (at_start_q) begin
			held_kind_d = word.kind;
			if (word.ch == dtoi_pkg::CH_PLUS) begin
				do_digit = 1'b0;
			end else if (word.ch == dtoi_pkg::CH_MINUS && kind_signed) begin
				is_negative_d = 1'b1;
			end else begin
				do_digit = 1'b1;
			end
		end else begin
			do_digit = !failed_q;
		end
		if (do_digit) begin
			if (!is_digit || overflow) begin
				failed_d = 1'b1;
			end else begin
				accum_d      = prod[dtoi_pkg::VALUE_W-1:0];
				digit_seen_d = 1'b1;
			end
		end
	end

	assign snap.accum       = accum_d;
	assign snap.is_negative = is_negative_d;
	assign snap.parsed      = !failed_d && digit_seen_d;
	assign snap.held_kind   = held_kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q       <= '0;
			is_negative_q <= 1'b0;
			failed_q      <= 1'b0;
			at_start_q    <= 1'b1;
			digit_seen_q  <= 1'b0;
			held_kind_q   <= dtoi_pkg::KIND_INT64;
		end else if (take) begin
			if (word.last) begin
				accum_q       <= '0;
				is_negative_q <= 1'b0;
				failed_q      <= 1'b0;
				at_start_q    <= 1'b1;
				digit_seen_q  <= 1'b0;
				held_kind_q   <= dtoi_pkg::KIND_INT64;
			end else begin
				accum_q       <= accum_d;
				is_negative_q <= is_negative_d;
				failed_q      <= failed_d;
				at_start_q    <= 1'b0;
				digit_seen_q  <= digit_seen_d;
				held_kind_q   <= held_kind_d;
			end
		end
	end

	// A finished text always leaves the state rearmed for the next one.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && word.last |=> at_start_q && (accum_q == '0) && !failed_q && !digit_seen_q)
		else $error("parse state not cleared after last character");

	// A minus sign is only ever held for a signed target.
	a_neg_signed: assert property (@(posedge clk) disable iff (!arst_n)
		is_negative_q |-> (held_kind_q == dtoi_pkg::KIND_INT64)
			|| (held_kind_q == dtoi_pkg::KIND_INT32))
		else $error("negative sign held for unsigned kind");

	// Mid-text, the state has left its start condition.
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		(is_negative_q || digit_seen_q || failed_q) |-> !at_start_q)
		else $error("progress recorded while still at start of text");

endmodule

`default_nettype wire

// ----- src/dtoi_range.sv -----
// Range check against the target kind and two's-complement result forming.
`default_nettype none

module dtoi_range (
	input  dtoi_pkg::text_snap_t snap,
	output dtoi_pkg::res_word_t  word
);

	logic                         fits;
	logic                         ok;
	logic [dtoi_pkg::VALUE_W-1:0] a;

	assign a = snap.accum;

	always_comb begin
		case (snap.held_kind)
			dtoi_pkg::KIND_INT64: begin
				// Magnitude 2^63 is allowed only for the most negative value.
				if (snap.is_negative) begin
					fits = !a[63] || (a[62:0] == '0);
				end else begin
					fits = !a[63];
				end
			end
			dtoi_pkg::KIND_UINT64: begin
				fits = 1'b1;
			end
			dtoi_pkg::KIND_INT32: begin
				if (snap.is_negative) begin
					fits = (a[63:32] == '0) && (!a[31] || (a[30:0] == '0));
				end else begin
					fits = (a[63:31] == '0);
				end
			end
			default: begin
				fits = (a[63:32] == '0);
			end
		endcase
	end

	assign ok = snap.parsed && fits;

	always_comb begin
		word.valid_res = ok;
		if (!ok) begin
			word.value = '0;
		end else if (snap.is_negative) begin
			word.value = '0 - a;
		end else begin
			word.value = a;
		end
	end

endmodule

`default_nettype wire

// ----- src/decimal_text_to_integer_core.sv -----
// Top level of the decimal text to integer converter: handshakes and stage registers.
`default_nettype none

// Takes one character word per cycle while the input is not stalled, with no gaps between texts.
// The result of a text passes from the input register through the parse state snapshot,
// then through the range check into the output register.
// A last character waits in the input register only while the snapshot and output stages
// are both full and the output is stalled; any other character never stalls the input.
// Reset clears all stage valid flags and rearms the parse state for a new text.

module decimal_text_to_integer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ch_valid,
	output logic                ch_stall,
	input  dtoi_pkg::ch_word_t  ch_word,
	output logic                res_valid,
	input  logic                res_stall,
	output dtoi_pkg::res_word_t res_word
);

	logic                 s1_v_q;
	dtoi_pkg::ch_word_t   ch_s1;
	logic                 s2_v_q;
	dtoi_pkg::text_snap_t snap_s2;
	logic                 res_v_q;
	dtoi_pkg::res_word_t  res_word_q;

	dtoi_pkg::text_snap_t snap;
	dtoi_pkg::res_word_t  final_word;

	logic res_free;
	logic s2_free;
	logic s1_move;

	assign res_free = !res_v_q || !res_stall;
	assign s2_free  = !s2_v_q || res_free;
	// Only a last character needs room downstream; others just update the state.
	assign s1_move  = s1_v_q && (!ch_s1.last || s2_free);
	assign ch_stall = s1_v_q && !s1_move;

	dtoi_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (s1_move),
		.word   (ch_s1),
		.snap   (snap)
	);

	dtoi_range u_range (
		.snap (snap_s2),
		.word (final_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (!ch_stall) begin
				s1_v_q <= ch_valid;
			end
			if (s2_free) begin
				s2_v_q <= s1_move && ch_s1.last;
			end
			if (res_free) begin
				res_v_q <= s2_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ch_stall && ch_valid) begin
			ch_s1 <= ch_word;
		end
		if (s1_move && ch_s1.last) begin
			snap_s2 <= snap;
		end
		if (res_free && s2_v_q) begin
			res_word_q <= final_word;
		end
	end

	assign res_valid = res_v_q;
	assign res_word  = res_word_q;

	// An invalid text always reports a zero value.
	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.valid_res |-> (res_word.value == '0))
		else $error("invalid result carries a nonzero value");

	// A last character that leaves the input stage lands in the snapshot stage.
	a_last_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && ch_s1.last |=> s2_v_q)
		else $error("finished text lost between stages");

	// The input side stalls only when the input stage holds a word it cannot pass on.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ch_stall |-> s1_v_q && ch_s1.last && s2_v_q && res_v_q && res_stall)
		else $error("input stalled without a full downstream");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for decimal_text_to_integer_core: directed texts, then predicted random texts.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned CHAR_TARGET = 650;
	localparam int unsigned DIR_ROWS = 9;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                ch_valid;
	logic                ch_stall;
	dtoi_pkg::ch_word_t  ch_word;
	logic                res_valid;
	logic                res_stall;
	dtoi_pkg::res_word_t res_word;

	decimal_text_to_integer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch_word  (ch_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word (res_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Directed texts. Rows with a typed result are checked against it instead of the predictor.
	string     dir_text  [DIR_ROWS] = '{"+", "-", "-0", "-7", "4+", "\377", "12", "+0",
		"-2147483648"};
	logic [1:0] dir_kind [DIR_ROWS] = '{dtoi_pkg::KIND_INT64, dtoi_pkg::KIND_INT32,
		dtoi_pkg::KIND_INT64, dtoi_pkg::KIND_UINT32, dtoi_pkg::KIND_UINT64,
		dtoi_pkg::KIND_UINT64, dtoi_pkg::KIND_UINT32, dtoi_pkg::KIND_UINT64,
		dtoi_pkg::KIND_INT32};
	bit        dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 0, 1, 1};
	dtoi_pkg::res_word_t dir_res [DIR_ROWS] = '{{64'd0, 1'b0}, {64'd0, 1'b0}, {64'd0, 1'b1},
		{64'd0, 1'b0}, {64'd0, 1'b0}, {64'd0, 1'b0}, {64'd0, 1'b0}, {64'd0, 1'b1},
		{64'hFFFF_FFFF_8000_0000, 1'b1}};

	dtoi_pkg::res_word_t pending_res [$];
	logic [7:0]  text_buf [$];
	int unsigned fails = 0;
	int unsigned cycles = 0;
	int unsigned chars_sent = 0;

	// Parser state of the predictor.
	logic [63:0] mag;
	bit          minus_taken;
	bit          broken;
	bit          first_pending;
	bit          any_digit;
	logic [1:0]  text_kind;

	task automatic absorb_digit(input logic [7:0] c);
		logic [63:0] d;
		if (c < dtoi_pkg::CH_ZERO || c > dtoi_pkg::CH_NINE) begin
			broken = 1'b1;
		end else begin
			d = 64'(c - dtoi_pkg::CH_ZERO);
			if (mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
				broken = 1'b1;
			end else begin
				mag = mag * 64'd10 + d;
				any_digit = 1'b1;
			end
		end
	endtask

	task automatic clear_parser();
		mag = '0;
		minus_taken = 1'b0;
		broken = 1'b0;
		first_pending = 1'b1;
		any_digit = 1'b0;
		text_kind = dtoi_pkg::KIND_INT64;
	endtask

	task automatic parse_char(input dtoi_pkg::ch_word_t w, output bit done,
		output dtoi_pkg::res_word_t r);
		bit fits;
		done = 1'b0;
		r = '0;
		if (first_pending) begin
			text_kind = w.kind;
			first_pending = 1'b0;
			if (w.ch == dtoi_pkg::CH_PLUS) begin
			end else if (w.ch == dtoi_pkg::CH_MINUS && (text_kind == dtoi_pkg::KIND_INT64
				|| text_kind == dtoi_pkg::KIND_INT32)) begin
				minus_taken = 1'b1;
			end else begin
				absorb_digit(w.ch);
			end
		end else if (!broken) begin
			absorb_digit(w.ch);
		end
		if (w.last) begin
			fits = !broken && any_digit;
			if (fits) begin
				case (text_kind)
					dtoi_pkg::KIND_INT64:
						fits = minus_taken ? mag <= (64'd1 << 63) : mag < (64'd1 << 63);
					dtoi_pkg::KIND_UINT64: fits = 1'b1;
					dtoi_pkg::KIND_INT32:
						fits = minus_taken ? mag <= (64'd1 << 31) : mag < (64'd1 << 31);
					default: fits = mag <= 64'hFFFF_FFFF;
				endcase
			end
			if (fits)
				r.value = minus_taken ? -mag : mag;
			r.valid_res = fits;
			done = 1'b1;
			clear_parser();
		end
	endtask

	// Entered and left at a falling edge.
	task automatic send_text(input logic [1:0] kind, input bit burst, input bit typed,
		input dtoi_pkg::res_word_t typed_res);
		dtoi_pkg::ch_word_t  w;
		bit                  done;
		dtoi_pkg::res_word_t r;
		int unsigned         gap;
		for (int i = 0; i < text_buf.size(); i++) begin
			w.ch = text_buf[i];
			w.last = (i == text_buf.size() - 1);
			w.kind = (i == 0) ? kind : 2'($urandom_range(0, 3));
			gap = burst ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				ch_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			ch_valid <= 1'b1;
			ch_word <= w;
			@(posedge clk);
			while (ch_stall)
				@(posedge clk);
			parse_char(w, done, r);
			if (done)
				pending_res.push_back(typed ? typed_res : r);
			chars_sent++;
			@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		ch_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_res.size() != 0);
	endtask

	// Builds one random text in text_buf: mostly well-formed numbers, some near the range edges.
	task automatic make_text();
		logic [79:0] m;
		logic [7:0]  pick;
		int unsigned len;
		text_buf.delete();
		if ($urandom_range(0, 99) < 80) begin
			case ($urandom_range(0, 9))
				0, 1: m = 80'($urandom_range(0, 999));
				2: m = 80'($urandom);
				3: m = (80'd1 << 31) - 80'd3 + 80'($urandom_range(0, 6));
				4: m = (80'd1 << 32) - 80'd3 + 80'($urandom_range(0, 6));
				5: m = (80'd1 << 63) - 80'd3 + 80'($urandom_range(0, 6));
				6: m = (80'd1 << 64) - 80'd3 + 80'($urandom_range(0, 6));
				7: m = 80'({$urandom, $urandom});
				8: m = 80'({$urandom, $urandom}) * 80'd1000 + 80'($urandom_range(0, 999));
				default: m = 80'($urandom_range(0, 99999));
			endcase
			if (m == 0)
				text_buf.push_front(dtoi_pkg::CH_ZERO);
			while (m != 0) begin
				text_buf.push_front(dtoi_pkg::CH_ZERO + 8'(m % 80'd10));
				m = m / 80'd10;
			end
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 3))
					text_buf.push_front(dtoi_pkg::CH_ZERO);
			end
			case ($urandom_range(0, 9))
				6, 7: text_buf.push_front(dtoi_pkg::CH_PLUS);
				8, 9: text_buf.push_front(dtoi_pkg::CH_MINUS);
				default: ;
			endcase
		end else if ($urandom_range(0, 4) == 0) begin
			text_buf.push_back($urandom_range(0, 1) ? dtoi_pkg::CH_PLUS : dtoi_pkg::CH_MINUS);
		end else begin
			len = $urandom_range(1, 6);
			repeat (len) begin
				case ($urandom_range(0, 19))
					0, 1, 2: pick = dtoi_pkg::CH_PLUS;
					3, 4, 5: pick = dtoi_pkg::CH_MINUS;
					6, 7, 8, 9: pick = 8'($urandom_range(0, 255));
					default: pick = dtoi_pkg::CH_ZERO + 8'($urandom_range(0, 9));
				endcase
				text_buf.push_back(pick);
			end
		end
	endtask

	// Receiver: may stall before each result; some runs of results are taken with no stall.
	initial begin
		int unsigned n;
		int unsigned taken;
		bit          no_stall;
		res_stall = 1'b0;
		taken = 0;
		no_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (taken % 8 == 0)
				no_stall = ($urandom_range(0, 99) < 30);
			n = no_stall ? 0 : $urandom_range(0, 15);
			if (n != 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(arst_n && res_valid));
			taken++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		dtoi_pkg::res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				$error("result word with nothing expected: value %h valid_res %b",
					res_word.value, res_word.valid_res);
				fails++;
			end else begin
				want = pending_res.pop_front();
				if (res_word.value !== want.value) begin
					$error("value mismatch: expected %h, actual %h", want.value, res_word.value);
					fails++;
				end
				if (res_word.valid_res !== want.valid_res) begin
					$error("valid_res mismatch: expected %b, actual %b", want.valid_res,
						res_word.valid_res);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		bit paused_mid;
		arst_n = 1'b0;
		ch_valid = 1'b0;
		ch_word = '0;
		paused_mid = 1'b0;
		clear_parser();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int row = 0; row < DIR_ROWS; row++) begin
			text_buf.delete();
			for (int k = 0; k < dir_text[row].len(); k++)
				text_buf.push_back(dir_text[row][k]);
			send_text(dir_kind[row], row % 3 == 0, dir_typed[row], dir_res[row]);
		end
		wait_drained();

		while (chars_sent < CHAR_TARGET) begin
			make_text();
			send_text(2'($urandom_range(0, 3)), $urandom_range(0, 99) < 25, 1'b0, '0);
			if (!paused_mid && chars_sent > CHAR_TARGET / 2) begin
				paused_mid = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
